// File: rtl/sst_pkg.sv
// Package: shared types and codes for the slot schedule table.
`timescale 1ns / 1ps
package sst_pkg;

  localparam logic [1:0] FN_ASSIGN = 2'd0;
  localparam logic [1:0] FN_MEMBER = 2'd1;
  localparam logic [1:0] FN_LOOKUP = 2'd2;
  localparam logic [1:0] FN_REMOVE = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_RANGE   = 3'd1;
  localparam logic [2:0] ST_ROLE    = 3'd2;
  localparam logic [2:0] ST_BUSY    = 3'd3;
  localparam logic [2:0] ST_NOT_OWN = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;
  localparam logic [2:0] ST_MISSING = 3'd6;

  localparam logic [1:0] REG_FRAME_LENGTH = 2'd0;
  localparam logic [1:0] REG_NODE_ROLE    = 2'd1;
  localparam logic [1:0] REG_OWN_GROUP    = 2'd2;

  localparam logic [1:0] ROLE_ROOT   = 2'd0;
  localparam logic [1:0] ROLE_LEADER = 2'd1;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  group_id;
    logic [7:0]  first_slot;
    logic [7:0]  last_slot;
    logic [63:0] member_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        entry_found;
    logic [7:0]  slot_offset;
    logic [3:0]  channel_offset;
    logic        entry_kind;
    logic [7:0]  entry_group;
    logic [63:0] neighbor;
    logic [5:0]  active_entries;
  } out_item_t;

  // Entry payload as stored in the table memory
  typedef struct packed {
    logic [7:0]  slot;
    logic [3:0]  channel;
    logic        is_member;
    logic [7:0]  group_id;
    logic [63:0] neighbor;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FILL,
    S_DONE
  } state_t;

endpackage

// File: rtl/slot_schedule_table.sv
// Top level: slot schedule table with memory-held entries and a scanning sequencer.
`timescale 1ns / 1ps
// Slot schedule table.
// Command channel: in_item is taken on a clock edge with start high and busy low.
// One result per item appears on out_item for one cycle with out_valid high;
// the receiver must take it then, it cannot stall the block.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects
// frame_length (0), node_role (1) or own_group (2). Write only while idle.
// Entry fields live in a one-port synchronous memory of TABLE_ENTRIES rows;
// valid bits are flip-flops. Every item scans the table one row per cycle
// through the registered memory read. The next item can be taken at the same
// edge at which the result is taken. A successful range assignment first
// writes one leader row per slot of the range before the result is shown.
// The scan through the single memory port sets the rate.
// Reset clears valid bits, the used count and the registers
// (frame_length 101, role root, group 0); no clearing pass is needed.
module slot_schedule_table #(
  parameter int TABLE_ENTRIES = 32,
  parameter int CHANNELS      = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sst_pkg::in_item_t  in_item,
  output logic               out_valid,
  output sst_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int SW = (CW + 1 > 9) ? CW + 1 : 9;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  // configuration registers
  logic [8:0] frame_length_r;
  logic [1:0] node_role_r;
  logic [7:0] own_group_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= 9'd101;
      node_role_r    <= 2'd0;
      own_group_r    <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sst_pkg::REG_FRAME_LENGTH: frame_length_r <= cfg_data;
        sst_pkg::REG_NODE_ROLE:    node_role_r    <= cfg_data[1:0];
        sst_pkg::REG_OWN_GROUP:    own_group_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // channel of each slot, fixed at elaboration
  logic [3:0] chan_lut [256];
  for (genvar g = 0; g < 256; g++) begin : g_chan
    assign chan_lut[g] = 4'(g % CHANNELS);
  end

  // entry memory and valid bits
  sst_pkg::entry_t mem [TABLE_ENTRIES];
  sst_pkg::entry_t rd_q;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic            mem_we;
  logic [IW-1:0]   mem_addr;
  sst_pkg::entry_t mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rd_q <= mem[mem_addr];
  end

  // sequencer state
  sst_pkg::state_t state_r, state_nxt;
  sst_pkg::in_item_t item_r, item_nxt;
  logic [IW-1:0] idx_r, idx_nxt;       // address being issued
  logic [IW-1:0] ridx_r, ridx_nxt;     // address of data in rd_q
  logic          rvld_r, rvld_nxt;     // rd_q holds a scanned row
  logic          hit_r, hit_nxt;       // found entry for addressed slot
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  sst_pkg::entry_t hit_e_r, hit_e_nxt;
  logic          busy_hit_r, busy_hit_nxt; // any entry inside range
  logic [7:0]    fill_slot_r, fill_slot_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic          outv_r, outv_nxt;
  sst_pkg::out_item_t res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sst_pkg::S_IDLE;
      valid_r <= '0;
      used_r  <= '0;
      outv_r  <= 1'b0;
      rvld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      used_r  <= used_nxt;
      outv_r  <= outv_nxt;
      rvld_r  <= rvld_nxt;
    end
    item_r      <= item_nxt;
    idx_r       <= idx_nxt;
    ridx_r      <= ridx_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_e_r     <= hit_e_nxt;
    busy_hit_r  <= busy_hit_nxt;
    fill_slot_r <= fill_slot_nxt;
    res_r       <= res_nxt;
  end

  // first free row, priority from row zero
  logic [IW-1:0] free_idx;
  always_comb begin
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = IW'(i);
    end
  end

  logic       range_bad;
  logic [8:0] span;
  logic [CW:0] free_cnt;
  always_comb begin
    if (item_r.func == sst_pkg::FN_ASSIGN)
      range_bad = ({1'b0, item_r.first_slot} >= frame_length_r) ||
                  ({1'b0, item_r.last_slot} >= frame_length_r) ||
                  (item_r.first_slot > item_r.last_slot);
    else
      range_bad = {1'b0, item_r.first_slot} >= frame_length_r;
    span     = {1'b0, item_r.last_slot} - {1'b0, item_r.first_slot} + 9'd1;
    free_cnt = (CW+1)'(TABLE_ENTRIES) - {1'b0, used_r};
  end

  always_comb begin
    logic [2:0] st;
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    used_nxt      = used_r;
    item_nxt      = item_r;
    idx_nxt       = idx_r;
    ridx_nxt      = idx_r;
    rvld_nxt      = 1'b0;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_e_nxt     = hit_e_r;
    busy_hit_nxt  = busy_hit_r;
    fill_slot_nxt = fill_slot_r;
    outv_nxt      = 1'b0;
    res_nxt       = res_r;
    mem_we        = 1'b0;
    mem_addr      = idx_r;
    mem_wd        = '0;
    st            = sst_pkg::ST_OK;

    // compare the row read last cycle
    if (rvld_r && valid_r[ridx_r]) begin
      if (rd_q.slot == item_r.first_slot && !hit_r) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = ridx_r;
        hit_e_nxt   = rd_q;
      end
      if (rd_q.slot >= item_r.first_slot && rd_q.slot <= item_r.last_slot)
        busy_hit_nxt = 1'b1;
    end

    case (state_r)
      sst_pkg::S_IDLE: begin
        if (start) begin
          item_nxt     = in_item;
          idx_nxt      = '0;
          hit_nxt      = 1'b0;
          busy_hit_nxt = 1'b0;
          state_nxt    = sst_pkg::S_SCAN;
        end
      end
      sst_pkg::S_SCAN: begin
        mem_addr = idx_r;
        rvld_nxt = 1'b1;
        if (idx_r == LAST_IDX) state_nxt = sst_pkg::S_DECIDE;
        else idx_nxt = idx_r + 1'b1;
      end
      sst_pkg::S_DECIDE: begin
        // last row's compare lands this cycle; use forwarded results
        res_nxt = '0;
        if (range_bad) st = sst_pkg::ST_RANGE;
        else begin
          case (item_r.func)
            sst_pkg::FN_ASSIGN: begin
              if (node_role_r != sst_pkg::ROLE_ROOT) st = sst_pkg::ST_ROLE;
              else if (busy_hit_nxt) st = sst_pkg::ST_BUSY;
              else if (SW'(free_cnt) < SW'(span)) st = sst_pkg::ST_FULL;
            end
            sst_pkg::FN_MEMBER: begin
              if (node_role_r != sst_pkg::ROLE_LEADER) st = sst_pkg::ST_ROLE;
              else if (!hit_nxt || hit_e_nxt.is_member ||
                       hit_e_nxt.group_id != own_group_r) st = sst_pkg::ST_NOT_OWN;
              else begin
                mem_we   = 1'b1;
                mem_addr = hit_idx_nxt;
                mem_wd   = hit_e_nxt;
                mem_wd.is_member = 1'b1;
                mem_wd.group_id  = own_group_r;
                mem_wd.neighbor  = item_r.member_address;
              end
            end
            sst_pkg::FN_LOOKUP: begin
              if (!hit_nxt) st = sst_pkg::ST_MISSING;
              else begin
                res_nxt.entry_found    = 1'b1;
                res_nxt.slot_offset    = hit_e_nxt.slot;
                res_nxt.channel_offset = hit_e_nxt.channel;
                res_nxt.entry_kind     = hit_e_nxt.is_member;
                res_nxt.entry_group    = hit_e_nxt.group_id;
                res_nxt.neighbor       = hit_e_nxt.is_member ? hit_e_nxt.neighbor : '0;
              end
            end
            sst_pkg::FN_REMOVE: begin
              if (!hit_nxt) st = sst_pkg::ST_MISSING;
              else begin
                valid_nxt[hit_idx_nxt] = 1'b0;
                used_nxt = used_r - 1'b1;
              end
            end
            default: ;
          endcase
        end
        res_nxt.status = st;
        if (item_r.func == sst_pkg::FN_ASSIGN && st == sst_pkg::ST_OK) begin
          fill_slot_nxt = item_r.first_slot;
          state_nxt     = sst_pkg::S_FILL;
        end else state_nxt = sst_pkg::S_DONE;
      end
      sst_pkg::S_FILL: begin
        // one new leader row per cycle into the first free row
        mem_we           = 1'b1;
        mem_addr         = free_idx;
        mem_wd.slot      = fill_slot_r;
        mem_wd.channel   = chan_lut[fill_slot_r];
        mem_wd.is_member = 1'b0;
        mem_wd.group_id  = item_r.group_id;
        mem_wd.neighbor  = '0;
        valid_nxt[free_idx] = 1'b1;
        used_nxt      = used_r + 1'b1;
        fill_slot_nxt = fill_slot_r + 8'd1;
        if (fill_slot_r == item_r.last_slot) state_nxt = sst_pkg::S_DONE;
      end
      sst_pkg::S_DONE: begin
        outv_nxt = 1'b1;
        res_nxt.active_entries = 6'(used_r);
        state_nxt = sst_pkg::S_IDLE;
      end
      default: state_nxt = sst_pkg::S_IDLE;
    endcase
  end

  // the result register frees the sequencer while the result is shown
  assign busy      = (state_r != sst_pkg::S_IDLE);
  assign out_valid = outv_r;
  assign out_item  = res_r;

  // checks
  a_used_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sst_pkg::S_IDLE) |-> (CW'($countones(valid_r)) == used_r))
    else $error("used count differs from valid bits");
  a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == sst_pkg::S_IDLE))
    else $error("result shown while sequencer active");
  a_fill_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sst_pkg::S_FILL) |-> !valid_r[free_idx])
    else $error("fill found no free row");

endmodule

// File: verif/tb_slot_schedule_table.sv
// Testbench for the slot schedule table: directed and random commands, scoreboard check.
`timescale 1ns / 1ps
module tb_slot_schedule_table;

  localparam int NUM_ENTRIES = 32;
  localparam int CHAN_COUNT = 16;
  localparam int RANDOM_ITEMS = 1830;
  localparam int CYCLE_LIMIT = 900000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  sst_pkg::in_item_t in_item = '0;
  logic out_valid;
  sst_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  // Scoreboard: mirror of the table, expected results in order
  class sched_scoreboard;
    bit ent_valid[NUM_ENTRIES];
    logic [7:0] ent_slot[NUM_ENTRIES];
    logic [3:0] ent_chan[NUM_ENTRIES];
    bit ent_member[NUM_ENTRIES];
    logic [7:0] ent_group[NUM_ENTRIES];
    logic [63:0] ent_nbr[NUM_ENTRIES];
    int unsigned used;
    logic [8:0] frame_len;
    logic [1:0] role;
    logic [7:0] my_group;
    sst_pkg::out_item_t pending_results[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned status_seen[8];

    function new();
      used = 0;
      frame_len = 9'd101;
      role = sst_pkg::ROLE_ROOT;
      my_group = 8'd0;
      errors = 0;
      checked = 0;
      foreach (ent_valid[i]) ent_valid[i] = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [8:0] val);
      case (idx)
        sst_pkg::REG_FRAME_LENGTH: frame_len = val;
        sst_pkg::REG_NODE_ROLE: role = val[1:0];
        sst_pkg::REG_OWN_GROUP: my_group = val[7:0];
        default: ;
      endcase
    endfunction

    function int find_slot(logic [7:0] s);
      for (int i = 0; i < NUM_ENTRIES; i++)
        if (ent_valid[i] && ent_slot[i] == s) return i;
      return -1;
    endfunction

    function logic [2:0] assign_range(sst_pkg::in_item_t it);
      int unsigned span;
      int k;
      if ({1'b0, it.first_slot} >= frame_len || {1'b0, it.last_slot} >= frame_len ||
          it.first_slot > it.last_slot)
        return sst_pkg::ST_RANGE;
      if (role != sst_pkg::ROLE_ROOT) return sst_pkg::ST_ROLE;
      for (int i = 0; i < NUM_ENTRIES; i++)
        if (ent_valid[i] && ent_slot[i] >= it.first_slot && ent_slot[i] <= it.last_slot)
          return sst_pkg::ST_BUSY;
      span = it.last_slot - it.first_slot + 1;
      if (NUM_ENTRIES - used < span) return sst_pkg::ST_FULL;
      k = 0;
      for (int s = it.first_slot; s <= it.last_slot; s++) begin
        while (ent_valid[k]) k++;
        ent_valid[k] = 1'b1;
        ent_slot[k] = s[7:0];
        ent_chan[k] = 4'(s % CHAN_COUNT);
        ent_member[k] = 1'b0;
        ent_group[k] = it.group_id;
        ent_nbr[k] = '0;
        used++;
      end
      return sst_pkg::ST_OK;
    endfunction

    // Note an accepted command and queue its expected result
    function void note_command(sst_pkg::in_item_t it);
      sst_pkg::out_item_t r;
      int idx;
      r = '0;
      case (it.func)
        sst_pkg::FN_ASSIGN: r.status = assign_range(it);
        sst_pkg::FN_MEMBER: begin
          if ({1'b0, it.first_slot} >= frame_len) r.status = sst_pkg::ST_RANGE;
          else if (role != sst_pkg::ROLE_LEADER) r.status = sst_pkg::ST_ROLE;
          else begin
            idx = find_slot(it.first_slot);
            if (idx < 0 || ent_member[idx] || ent_group[idx] != my_group)
              r.status = sst_pkg::ST_NOT_OWN;
            else begin
              ent_member[idx] = 1'b1;
              ent_group[idx] = my_group;
              ent_nbr[idx] = it.member_address;
              r.status = sst_pkg::ST_OK;
            end
          end
        end
        default: begin
          if ({1'b0, it.first_slot} >= frame_len) r.status = sst_pkg::ST_RANGE;
          else begin
            idx = find_slot(it.first_slot);
            if (idx < 0) r.status = sst_pkg::ST_MISSING;
            else if (it.func == sst_pkg::FN_LOOKUP) begin
              r.status = sst_pkg::ST_OK;
              r.entry_found = 1'b1;
              r.slot_offset = ent_slot[idx];
              r.channel_offset = ent_chan[idx];
              r.entry_kind = ent_member[idx];
              r.entry_group = ent_group[idx];
              r.neighbor = ent_member[idx] ? ent_nbr[idx] : '0;
            end else begin
              r.status = sst_pkg::ST_OK;
              ent_valid[idx] = 1'b0;
              used--;
            end
          end
        end
      endcase
      r.active_entries = used[5:0];
      status_seen[r.status]++;
      pending_results.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, checked);
      errors++;
    endtask

    // Compare one result with the oldest expectation
    task check_result(sst_pkg::out_item_t got);
      sst_pkg::out_item_t w;
      if (pending_results.size() == 0) begin
        report("unexpected result", 64'(got.status), 64'd0);
        return;
      end
      w = pending_results.pop_front();
      if (got.status !== w.status) report("status", got.status, w.status);
      if (got.entry_found !== w.entry_found)
        report("entry_found", got.entry_found, w.entry_found);
      if (got.slot_offset !== w.slot_offset)
        report("slot_offset", got.slot_offset, w.slot_offset);
      if (got.channel_offset !== w.channel_offset)
        report("channel_offset", got.channel_offset, w.channel_offset);
      if (got.entry_kind !== w.entry_kind) report("entry_kind", got.entry_kind, w.entry_kind);
      if (got.entry_group !== w.entry_group)
        report("entry_group", got.entry_group, w.entry_group);
      if (got.neighbor !== w.neighbor) report("neighbor", got.neighbor, w.neighbor);
      if (got.active_entries !== w.active_entries)
        report("active_entries", got.active_entries, w.active_entries);
      checked++;
    endtask
  endclass

  sched_scoreboard sb;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  slot_schedule_table u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result monitor and watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) sb.check_result(out_item);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // Send one command; gaps may come between bursts
  task send_cmd(sst_pkg::in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 40)) @(negedge clk);
    end
    burst_left--;
    // start was dropped at an earlier falling edge
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(it);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task wait_drained();
    @(negedge clk);
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write, only while idle
  task write_reg(logic [1:0] idx, logic [8:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic sst_pkg::in_item_t make_cmd(logic [1:0] f, logic [7:0] g,
                                                 logic [7:0] a, logic [7:0] b,
                                                 logic [63:0] addr);
    sst_pkg::in_item_t it;
    it.func = f;
    it.group_id = g;
    it.first_slot = a;
    it.last_slot = b;
    it.member_address = addr;
    return it;
  endfunction

  function automatic logic [63:0] rand_addr();
    return {$urandom(), $urandom()};
  endfunction

  // Random command biased toward a first slot inside the frame
  task random_cmd(int unsigned fl);
    logic [7:0] a, b;
    logic [1:0] f;
    int unsigned lim;
    lim = (fl == 0) ? 0 : fl - 1;
    if ($urandom_range(0, 9) == 0) begin
      a = 8'($urandom());
      b = 8'($urandom());
    end else begin
      a = 8'($urandom_range(0, lim > 255 ? 255 : lim));
      b = 8'(a + $urandom_range(0, 5));
    end
    f = 2'($urandom());
    send_cmd(make_cmd(f, ($urandom_range(0, 3) == 0) ? 8'($urandom()) : sb.my_group, a, b,
                      rand_addr()));
  endtask

  initial begin
    sb = new();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: range checks, busy, full, roles, member conversion, lookups
    send_cmd(make_cmd(sst_pkg::FN_ASSIGN, 8'd7, 8'd0, 8'd3, '0));
    send_cmd(make_cmd(sst_pkg::FN_ASSIGN, 8'd7, 8'd2, 8'd5, '0));
    send_cmd(make_cmd(sst_pkg::FN_ASSIGN, 8'd7, 8'd9, 8'd8, '0));
    send_cmd(make_cmd(sst_pkg::FN_ASSIGN, 8'd7, 8'd99, 8'd101, '0));
    send_cmd(make_cmd(sst_pkg::FN_LOOKUP, 8'd0, 8'd2, 8'd0, '0));
    send_cmd(make_cmd(sst_pkg::FN_LOOKUP, 8'd0, 8'd200, 8'd0, '0));
    send_cmd(make_cmd(sst_pkg::FN_REMOVE, 8'd0, 8'd50, 8'd0, '0));
    send_cmd(make_cmd(sst_pkg::FN_MEMBER, 8'd0, 8'd1, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF));
    send_cmd(make_cmd(sst_pkg::FN_ASSIGN, 8'hFF, 8'd10, 8'd40, '0));
    send_cmd(make_cmd(sst_pkg::FN_ASSIGN, 8'hFF, 8'd60, 8'd87, '0));
    send_cmd(make_cmd(sst_pkg::FN_REMOVE, 8'd0, 8'd0, 8'd0, '0));
    write_reg(sst_pkg::REG_NODE_ROLE, 9'(sst_pkg::ROLE_LEADER));
    write_reg(sst_pkg::REG_OWN_GROUP, 9'hFF);
    send_cmd(make_cmd(sst_pkg::FN_ASSIGN, 8'd1, 8'd90, 8'd90, '0));
    send_cmd(make_cmd(sst_pkg::FN_MEMBER, 8'd0, 8'd60, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF));
    send_cmd(make_cmd(sst_pkg::FN_MEMBER, 8'd0, 8'd60, 8'd0, 64'h1));
    send_cmd(make_cmd(sst_pkg::FN_MEMBER, 8'd0, 8'd1, 8'd0, 64'h1));
    send_cmd(make_cmd(sst_pkg::FN_MEMBER, 8'd0, 8'd70, 8'd0, 64'h5555_AAAA_0F0F_F0F0));
    send_cmd(make_cmd(sst_pkg::FN_LOOKUP, 8'd0, 8'd60, 8'd0, '0));
    send_cmd(make_cmd(sst_pkg::FN_LOOKUP, 8'd0, 8'd70, 8'd0, '0));
    write_reg(sst_pkg::REG_FRAME_LENGTH, 9'd65);
    send_cmd(make_cmd(sst_pkg::FN_LOOKUP, 8'd0, 8'd70, 8'd0, '0));
    send_cmd(make_cmd(sst_pkg::FN_REMOVE, 8'd0, 8'd64, 8'd0, '0));
    write_reg(sst_pkg::REG_FRAME_LENGTH, 9'd0);
    send_cmd(make_cmd(sst_pkg::FN_LOOKUP, 8'd0, 8'd0, 8'd0, '0));
    write_reg(sst_pkg::REG_NODE_ROLE, 9'd3);
    write_reg(sst_pkg::REG_FRAME_LENGTH, 9'd256);
    send_cmd(make_cmd(sst_pkg::FN_MEMBER, 8'd0, 8'd255, 8'd0, '0));

    // Random phases through several register settings
    for (int ph = 0; ph < 12; ph++) begin
      int unsigned fl;
      case (ph % 4)
        0: fl = 256;
        1: fl = 1;
        2: fl = $urandom_range(2, 40);
        default: fl = $urandom_range(1, 256);
      endcase
      write_reg(sst_pkg::REG_FRAME_LENGTH, 9'(fl));
      write_reg(sst_pkg::REG_NODE_ROLE, 9'((ph % 3 == 2) ? $urandom_range(2, 3) : ph % 2));
      write_reg(sst_pkg::REG_OWN_GROUP, 9'((ph == 5) ? 0 : $urandom_range(0, 255)));
      for (int n = 0; n < RANDOM_ITEMS / 12; n++) begin
        random_cmd(fl);
        if (n == 40) wait_drained();
      end
    end

    wait_drained();
    $display("ran %0d commands: ok %0d, range %0d, role %0d, busy %0d, not-own %0d,",
             sb.checked, sb.status_seen[sst_pkg::ST_OK], sb.status_seen[sst_pkg::ST_RANGE],
             sb.status_seen[sst_pkg::ST_ROLE], sb.status_seen[sst_pkg::ST_BUSY],
             sb.status_seen[sst_pkg::ST_NOT_OWN]);
    $display("full %0d, missing %0d, over frame lengths 0 to 256 and all roles",
             sb.status_seen[sst_pkg::ST_FULL], sb.status_seen[sst_pkg::ST_MISSING]);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
